// ===== sv/counting_sort_offset_index_builder_assert.svh =====
// Assertion macros for the compressed-row index builder.
// Used by the top level only; needs a clk and rst in scope.
`ifndef COUNTING_SORT_OFFSET_INDEX_BUILDER_ASSERT_SVH
`define COUNTING_SORT_OFFSET_INDEX_BUILDER_ASSERT_SVH
// property that must hold while out of reset
`define CSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the condition
`define CSB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== sv/csb_pkg.sv =====
// Shared constants and types for the compressed-row index builder.
// No dependencies.
package csb_pkg;
  localparam int MaxJoints = 4096;
  localparam int MaxPoints = 8192;
  localparam int JW = $clog2(MaxJoints + 1);
  localparam int PW = $clog2(MaxPoints + 1);
  localparam int JAW = $clog2(MaxJoints + 1);
  localparam int PAW = $clog2(MaxPoints);

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_BUILD = 3'd1;
  localparam logic [2:0] REQ_READ_ENTRY = 3'd2;
  localparam logic [2:0] REQ_READ_OFFSET = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BUCKET = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_INDEX = 3'd3;
  localparam logic [2:0] ST_NOTBUILT = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] feature;
    logic [15:0] point;
    logic [13:0] value;
  } result_t;
endpackage

// ===== sv/csb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module csb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/csb_ctrl.sv =====
// Sequencer for appends, clears, reads and the four-pass index build.
// Depends on csb_pkg; drives the three RAMs in the top level.
module csb_ctrl import csb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [12:0] cfg_joints,
  input  logic in_fire,
  input  logic [2:0] req_type,
  input  logic [31:0] feature_id,
  input  logic [15:0] point_id,
  input  logic [11:0] joint_id,
  input  logic [13:0] read_index,
  output logic busy,
  output logic res_valid,
  output result_t res,
  input  logic res_take,
  output logic raw_we,
  output logic [PAW-1:0] raw_waddr,
  output logic [59:0] raw_wdata,
  output logic [PAW-1:0] raw_raddr,
  input  logic [59:0] raw_rdata,
  output logic off_we,
  output logic [JAW-1:0] off_waddr,
  output logic [13:0] off_wdata,
  output logic [JAW-1:0] off_raddr,
  input  logic [13:0] off_rdata,
  output logic srt_we,
  output logic [PAW-1:0] srt_waddr,
  output logic [47:0] srt_wdata,
  output logic [PAW-1:0] srt_raddr,
  input  logic [47:0] srt_rdata
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_CNT = 4'd2;
  localparam logic [3:0] S_SUM = 4'd3;
  localparam logic [3:0] S_SCT = 4'd4;
  localparam logic [3:0] S_RDE = 4'd5;
  localparam logic [3:0] S_RDO = 4'd6;
  localparam logic [3:0] S_FIN = 4'd7;

  logic [3:0] state, state_next;
  logic [PW-1:0] entry_count;
  logic built;
  logic [12:0] nb;
  logic [PW-1:0] idx;
  logic raw_v;
  logic rd_v;
  logic [JAW-1:0] rd_b;
  logic [59:0] rd_e;
  logic fw_v;
  logic [JAW-1:0] fw_b;
  logic [13:0] fw_d;
  logic [13:0] sum, placed;
  logic skipped;
  logic [13:0] cur;
  logic [11:0] rb;
  logic [12:0] cfg_nb;

  assign busy = (state != S_IDLE) || res_valid;
  assign cfg_nb = (cfg_joints == 13'd0) ? 13'd1 :
                  (cfg_joints > 13'(MaxJoints)) ? 13'(MaxJoints) : cfg_joints;
  assign rb = raw_rdata[59:48];
  assign cur = (fw_v && fw_b == rd_b) ? fw_d : off_rdata;

  always_comb begin
    raw_we = 1'b0;
    raw_waddr = entry_count[PAW-1:0];
    raw_wdata = {joint_id, point_id, feature_id};
    raw_raddr = idx[PAW-1:0];
    off_we = 1'b0;
    off_waddr = idx[JAW-1:0];
    off_wdata = 14'd0;
    off_raddr = idx[JAW-1:0];
    srt_we = 1'b0;
    srt_waddr = cur[PAW-1:0];
    srt_wdata = rd_e[47:0];
    srt_raddr = read_index[PAW-1:0];
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_APPEND && {1'b0, joint_id} < nb
              && entry_count < PW'(MaxPoints)) begin
            raw_we = 1'b1;
          end
          if (req_type == REQ_BUILD) begin
            state_next = S_CLR;
          end
          if (req_type == REQ_READ_ENTRY && built && read_index < sum) begin
            state_next = S_RDE;
          end
          if (req_type == REQ_READ_OFFSET && built && {1'b0, read_index} <= {2'b0, nb}) begin
            off_raddr = read_index[JAW-1:0];
            state_next = S_RDO;
          end
        end
      end
      S_CLR: begin
        off_we = 1'b1;
        if (idx == PW'(nb)) begin
          state_next = S_CNT;
        end
      end
      S_CNT, S_SCT: begin
        off_raddr = JAW'({1'b0, rb} + 13'd1);
        if (rd_v && {1'b0, rd_b} <= JAW'(nb) && rd_b != '0) begin
          if (state == S_CNT) begin
            off_we = 1'b1;
            off_waddr = rd_b;
            off_wdata = cur + 14'd1;
          end else begin
            off_we = 1'b1;
            off_waddr = rd_b;
            off_wdata = cur + 14'd1;
            srt_we = 1'b1;
          end
        end
        if (idx == entry_count && !raw_v && !rd_v) begin
          state_next = (state == S_CNT) ? S_SUM : S_FIN;
        end
      end
      S_SUM: begin
        off_raddr = JAW'(idx + 1'b1);
        if (rd_v) begin
          off_we = 1'b1;
          off_waddr = rd_b;
          off_wdata = placed;
        end
        if (idx == PW'(nb) && !rd_v) begin
          state_next = S_SCT;
        end
      end
      S_RDE, S_RDO, S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      built <= 1'b0;
      nb <= 13'(MaxJoints);
      res_valid <= 1'b0;
      idx <= '0;
      raw_v <= 1'b0;
      rd_v <= 1'b0;
      fw_v <= 1'b0;
      sum <= '0;
    end else begin
      state <= state_next;
      if (res_take) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        nb <= cfg_nb;
        built <= 1'b0;
      end
      fw_v <= off_we;
      fw_b <= off_waddr;
      fw_d <= off_wdata;
      case (state)
        S_IDLE: begin
          idx <= '0;
          raw_v <= 1'b0;
          rd_v <= 1'b0;
          if (in_fire) begin
            res <= '0;
            case (req_type)
              REQ_APPEND: begin
                res.value <= entry_count[13:0];
                if ({1'b0, joint_id} >= nb) begin
                  res.status <= ST_BUCKET;
                  res_valid <= 1'b1;
                end else if (entry_count >= PW'(MaxPoints)) begin
                  res.status <= ST_FULL;
                  res_valid <= 1'b1;
                end else begin
                  entry_count <= entry_count + 1'b1;
                  res.value <= 14'(entry_count + 1'b1);
                  built <= 1'b0;
                  res_valid <= 1'b1;
                end
              end
              REQ_BUILD: begin
                skipped <= 1'b0;
              end
              REQ_READ_ENTRY: begin
                if (!built) begin
                  res.status <= ST_NOTBUILT;
                  res_valid <= 1'b1;
                end else if (read_index >= sum) begin
                  res.status <= ST_INDEX;
                  res_valid <= 1'b1;
                end
              end
              REQ_READ_OFFSET: begin
                if (!built) begin
                  res.status <= ST_NOTBUILT;
                  res_valid <= 1'b1;
                end else if ({1'b0, read_index} > {2'b0, nb}) begin
                  res.status <= ST_INDEX;
                  res_valid <= 1'b1;
                end
              end
              REQ_CLEAR: begin
                entry_count <= '0;
                built <= 1'b0;
                res_valid <= 1'b1;
              end
              default: begin
                res.status <= ST_INDEX;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_CLR: begin
          idx <= (idx == PW'(nb)) ? '0 : idx + 1'b1;
          placed <= '0;
        end
        S_CNT, S_SCT: begin
          raw_v <= (idx != entry_count);
          rd_v <= raw_v;
          rd_b <= JAW'({1'b0, rb} + 13'd1);
          rd_e <= raw_rdata;
          if (idx != entry_count) begin
            idx <= idx + 1'b1;
          end
          if (rd_v && {1'b0, rd_b} > JAW'(nb)) begin
            skipped <= 1'b1;
          end
          if (rd_v && state == S_SCT && {1'b0, rd_b} <= JAW'(nb)) begin
            placed <= placed + 14'd1;
          end
          if (idx == entry_count && !raw_v && !rd_v) begin
            idx <= '0;
            placed <= '0;
          end
        end
        S_SUM: begin
          rd_v <= (idx != PW'(nb));
          rd_b <= JAW'(idx + 1'b1);
          if (idx != PW'(nb)) begin
            idx <= idx + 1'b1;
          end
          if (rd_v) begin
            placed <= placed + cur;
          end
          if (idx == PW'(nb) && !rd_v) begin
            sum <= placed;
            idx <= '0;
            placed <= '0;
          end
        end
        S_RDE: begin
          res.feature <= srt_rdata[31:0];
          res.point <= srt_rdata[47:32];
          res_valid <= 1'b1;
        end
        S_RDO: begin
          res.value <= off_rdata;
          res_valid <= 1'b1;
        end
        S_FIN: begin
          built <= 1'b1;
          res.status <= skipped ? ST_BUCKET : ST_OK;
          res.value <= sum;
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/counting_sort_offset_index_builder.sv =====
// Compressed-row index builder: appends entries, builds a bucket-sorted index by
// counting sort, and serves sorted-entry and bucket-offset reads. Appends, clears,
// rejected requests and reads are each answered through a result register. A build
// walks the offset store to clear it and to prefix-sum it, and the raw store twice,
// once to count the entries per bucket and once to scatter them.
// Depends on csb_pkg, csb_ram, csb_ctrl and the assertion header.
`include "counting_sort_offset_index_builder_assert.svh"
module counting_sort_offset_index_builder import csb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  // feature_id[31:0], point_id[47:32], joint_id[59:48], read_index[73:60], pad
  input  logic [79:0] s_tdata,
  // req_type
  input  logic [2:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_feature[31:0], out_point[47:32], out_value[61:48], pad
  output logic [63:0] m_tdata,
  // status
  output logic [2:0] m_tuser
);
  logic [12:0] num_joints;
  logic cfg_we, busy, in_fire;
  result_t res;
  logic raw_we, off_we, srt_we;
  logic [PAW-1:0] raw_waddr, raw_raddr, srt_waddr, srt_raddr;
  logic [JAW-1:0] off_waddr, off_raddr;
  logic [59:0] raw_wdata, raw_rdata;
  logic [13:0] off_wdata, off_rdata;
  logic [47:0] srt_wdata, srt_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr == 3'd0;
  assign prdata = (paddr == 3'd0) ? {19'd0, num_joints} : 32'd0;
  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {2'b0, res.value, res.point, res.feature};
  assign m_tuser = res.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_joints <= 13'(MaxJoints);
    end else if (cfg_we) begin
      num_joints <= pwdata[12:0];
    end
  end

  csb_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_joints(pwdata[12:0]), .in_fire,
    .req_type(s_tuser), .feature_id(s_tdata[31:0]), .point_id(s_tdata[47:32]),
    .joint_id(s_tdata[59:48]), .read_index(s_tdata[73:60]),
    .busy, .res_valid(m_tvalid), .res, .res_take(m_tvalid && m_tready),
    .raw_we, .raw_waddr, .raw_wdata, .raw_raddr, .raw_rdata,
    .off_we, .off_waddr, .off_wdata, .off_raddr, .off_rdata,
    .srt_we, .srt_waddr, .srt_wdata, .srt_raddr, .srt_rdata
  );

  csb_ram #(.Width(60), .Depth(MaxPoints)) u_raw (
    .clk, .we(raw_we), .waddr(raw_waddr), .wdata(raw_wdata),
    .raddr(raw_raddr), .rdata(raw_rdata)
  );
  csb_ram #(.Width(14), .Depth(2 ** JAW)) u_off (
    .clk, .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );
  csb_ram #(.Width(48), .Depth(MaxPoints)) u_srt (
    .clk, .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .raddr(srt_raddr), .rdata(srt_rdata)
  );

  `CSB_ASSERT(a_no_accept_busy, !(m_tvalid && s_tready), "input taken while result pending")
  `CSB_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `CSB_ASSERT(a_status_range, !m_tvalid || m_tuser <= ST_NOTBUILT, "bad status code")
endmodule
